/* rtl/core/ievq_pkg.sv */
package ievq_pkg;

  // Default ring depth; one slot always stays free to tell full from empty.
  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned KEY_TABLE_SIZE = 232;

  // Coordinate fixed point: Q1.16 one and one half LSB of the result.
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [32:0] HALF_Q16 = 33'h0_0000_8000;

  // Configuration register reset values.
  localparam logic [15:0] ABS_MAX_X_RST  = 16'd32767;
  localparam logic [15:0] ABS_MAX_Y_RST  = 16'd32767;
  localparam logic [9:0]  TOUCH_CODE_RST = 10'd330;

  // Event types.
  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_ABS = 5'd3;
  localparam logic [4:0] EV_REP = 5'd20;

  // Axis codes of absolute events.
  localparam logic [9:0] ABS_X = 10'd0;
  localparam logic [9:0] ABS_Y = 10'd1;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_DELIVERED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_PTR  = 2'd1,
    KIND_TAKE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    KP_PRESSED   = 2'd0,
    KP_RELEASED  = 2'd1,
    KP_CANCELLED = 2'd2,
    KP_REPEAT    = 2'd3
  } key_phase_e;

  typedef enum logic [2:0] {
    PP_ADD    = 3'd0,
    PP_HOVER  = 3'd1,
    PP_DOWN   = 3'd2,
    PP_MOVE   = 3'd3,
    PP_UP     = 3'd4,
    PP_REMOVE = 3'd5,
    PP_CANCEL = 3'd6
  } ptr_phase_e;

  typedef enum logic [1:0] {
    CFG_ABS_MAX_X  = 2'd0,
    CFG_ABS_MAX_Y  = 2'd1,
    CFG_TOUCH_CODE = 2'd2
  } cfg_idx_e;

  // One ring entry: type, code, value.
  typedef struct packed {
    logic [4:0]  ev_type;
    logic [9:0]  code;
    logic [15:0] value;
  } evt_t;

  localparam int unsigned EVT_W = $bits(evt_t);

  // HID keyboard usage to key code.
  localparam logic [7:0] KEY_ROM [KEY_TABLE_SIZE] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd30, 8'd48, 8'd46, 8'd32,
    8'd18, 8'd33, 8'd34, 8'd35, 8'd23, 8'd36, 8'd37, 8'd38,
    8'd50, 8'd49, 8'd24, 8'd25, 8'd16, 8'd19, 8'd31, 8'd20,
    8'd22, 8'd47, 8'd17, 8'd45, 8'd21, 8'd44, 8'd2, 8'd3,
    8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
    8'd28, 8'd1, 8'd14, 8'd15, 8'd57, 8'd12, 8'd13, 8'd26,
    8'd27, 8'd43, 8'd43, 8'd39, 8'd40, 8'd41, 8'd51, 8'd52,
    8'd53, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64,
    8'd65, 8'd66, 8'd67, 8'd68, 8'd87, 8'd88, 8'd99, 8'd70,
    8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
    8'd105, 8'd108, 8'd103, 8'd69, 8'd98, 8'd55, 8'd74, 8'd78,
    8'd96, 8'd79, 8'd80, 8'd81, 8'd75, 8'd76, 8'd77, 8'd71,
    8'd72, 8'd73, 8'd82, 8'd83, 8'd86, 8'd127, 8'd116, 8'd117,
    8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190,
    8'd191, 8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
    8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
    8'd115, 8'd114,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0,
    8'd29, 8'd42, 8'd56, 8'd125, 8'd97, 8'd54, 8'd100, 8'd126
  };

endpackage

/* rtl/core/input_event_to_evdev_queue_core.sv */
// Each item goes from IDLE to PUSH for a key or pointer group, or to READ for a take, then to DONE;
// an ignored or dropped item, or a take from an empty ring, goes straight to DONE, and DONE waits
// out any output stall. No new item is taken until DONE has handed on the last result; the single
// ring write port writes one event per cycle.
// Reset (asynchronous, active low) empties the ring and loads the register defaults;
// ring contents are not cleared.
module input_event_to_evdev_queue_core import ievq_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(RING_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         key_usage_i,
  input  logic [1:0]         key_phase_i,
  input  logic [2:0]         pointer_phase_i,
  input  logic signed [17:0] x_pos_i,
  input  logic signed [17:0] y_pos_i,

  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [4:0]         event_type_o,
  output logic [9:0]         event_code_o,
  output logic [15:0]        event_value_o,

  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W + 1)'(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // The sequencer is one-hot. IDLE takes an item, PUSH writes one ring entry per
  // cycle, READ waits for the registered ring read, DONE hands the result to the
  // output register as soon as that register is free.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  rd_q, rd_d;
  logic [IDX_W-1:0]  wr_q, wr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [2:0]        n_q, n_d;
  logic              is_kbd_q, is_kbd_d;
  evt_t              ev0_q, ev0_d;
  status_e           res_status_q, res_status_d;
  evt_t              res_ev_q, res_ev_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  evt_t              out_ev_q;
  logic              out_load;

  logic [15:0]       abs_max_x_q;
  logic [15:0]       abs_max_y_q;
  logic [9:0]        touch_code_q;

  logic              in_acc;
  logic              usage_ok;
  logic [9:0]        key_code;
  logic [IDX_W:0]    ring_free;
  logic              grp_req;
  logic              last_entry;
  logic [15:0]       x_val;
  logic [15:0]       y_val;

  logic              ram_we;
  logic              ram_re;
  evt_t              ram_wdata;
  logic [EVT_W-1:0]  ram_rdata;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    next_slot = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Configuration writes are always taken; the user must send them only while idle; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_max_x_q  <= ABS_MAX_X_RST;
      abs_max_y_q  <= ABS_MAX_Y_RST;
      touch_code_q <= TOUCH_CODE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ABS_MAX_X:  abs_max_x_q  <= cfg_data_i;
        CFG_ABS_MAX_Y:  abs_max_y_q  <= cfg_data_i;
        CFG_TOUCH_CODE: touch_code_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Both axes are scaled at acceptance; the products stay put while the group is written.
  ievq_scale u_scale_x (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .pos_i   (x_pos_i),
    .max_i   (abs_max_x_q),
    .value_o (x_val)
  );

  ievq_scale u_scale_y (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .pos_i   (y_pos_i),
    .max_i   (abs_max_y_q),
    .value_o (y_val)
  );

  assign usage_ok = key_usage_i < 8'(KEY_TABLE_SIZE);
  assign key_code = usage_ok ? {2'b00, KEY_ROM[key_usage_i]} : '0;

  // Free slots, keeping one slot empty so that equal indexes mean an empty ring.
  assign ring_free = (rd_q > wr_q) ?
                     ({1'b0, rd_q} - {1'b0, wr_q} - 1'b1) :
                     ({1'b0, rd_q} + DEPTH_W - {1'b0, wr_q} - 1'b1);

  // The last entry of every group is the sync event.
  assign last_entry = (cnt_q == n_q[1:0] - 2'd1);

  always_comb begin
    if (last_entry) begin
      ram_wdata = '{ev_type: EV_SYN, code: '0, value: '0};
    end else if (is_kbd_q) begin
      ram_wdata = ev0_q;
    end else begin
      case (cnt_q)
        2'd0:    ram_wdata = '{ev_type: EV_ABS, code: ABS_X, value: x_val};
        2'd1:    ram_wdata = '{ev_type: EV_ABS, code: ABS_Y, value: y_val};
        default: ram_wdata = ev0_q;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    is_kbd_d     = is_kbd_q;
    ev0_d        = ev0_q;
    res_status_d = res_status_q;
    res_ev_d     = res_ev_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    grp_req      = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_IGNORED;
          res_ev_d     = '0;
          state_d      = S_DONE;
          case (kind_i)
            KIND_KEY: begin
              if (usage_ok) begin
                ev0_d.ev_type = (key_phase_i == KP_REPEAT) ? EV_REP : EV_KEY;
                ev0_d.code    = key_code;
                ev0_d.value   = (key_phase_i == KP_PRESSED || key_phase_i == KP_REPEAT) ?
                                16'd1 : 16'd0;
                n_d           = 3'd2;
                is_kbd_d      = 1'b1;
                grp_req       = 1'b1;
              end
            end
            KIND_PTR: begin
              case (pointer_phase_i) inside
                PP_DOWN, PP_MOVE, PP_UP: begin
                  // The touch event is kept for the third entry of a down or up group.
                  ev0_d.ev_type = EV_KEY;
                  ev0_d.code    = touch_code_q;
                  ev0_d.value   = (pointer_phase_i == PP_DOWN) ? 16'd1 : 16'd0;
                  n_d           = (pointer_phase_i == PP_MOVE) ? 3'd3 : 3'd4;
                  is_kbd_d      = 1'b0;
                  grp_req       = 1'b1;
                end
                default: ;
              endcase
            end
            KIND_TAKE: begin
              if (rd_q == wr_q) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end
            end
            default: ;
          endcase
          // A group goes in whole or not at all.
          if (grp_req) begin
            if (ring_free >= (IDX_W + 1)'(n_d)) begin
              cnt_d   = '0;
              state_d = S_PUSH;
            end else begin
              res_status_d = ST_DROPPED;
            end
          end
        end
      end
      S_PUSH: begin
        ram_we = 1'b1;
        wr_d   = next_slot(wr_q);
        cnt_d  = cnt_q + 2'd1;
        if (last_entry) begin
          res_status_d = ST_ACCEPTED;
          res_ev_d     = '0;
          state_d      = S_DONE;
        end
      end
      S_READ: begin
        res_ev_d     = evt_t'(ram_rdata);
        res_status_d = ST_DELIVERED;
        rd_d         = next_slot(rd_q);
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The output register lets the next item in while a result still waits to be taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    n_q          <= n_d;
    is_kbd_q     <= is_kbd_d;
    ev0_q        <= ev0_d;
    res_status_q <= res_status_d;
    res_ev_q     <= res_ev_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_ev_q     <= res_ev_q;
    end
  end

  // Reads and writes of the ring happen in different states, so they never meet.
  ievq_ram #(
    .WIDTH (EVT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign event_type_o  = out_ev_q.ev_type;
  assign event_code_o  = out_ev_q.code;
  assign event_value_o = out_ev_q.value;

  // A write never fills the last free slot.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (next_slot(wr_q) != rd_q))
    else $error("ring write overran the read index");

  // Only a non-empty ring is read.
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (rd_q != wr_q))
    else $error("ring read while empty");

  // The entry counter stays within the group being written.
  a_cnt_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> ((3'(cnt_q) < n_q) && (n_q >= 3'd2)))
    else $error("group entry counter out of range");

  // A finished result is taken over by the output register exactly when it is free.
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !(out_valid_q && out_stall_i)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded into the output register");

endmodule

/* rtl/core/ievq_ram.sv */
module ievq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ievq_scale.sv */
module ievq_scale import ievq_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [17:0] pos_i,
  input  logic [15:0]        max_i,
  output logic [15:0]        value_o
);

  logic [16:0] pos_clamp;
  logic [32:0] prod_q;
  logic [32:0] rounded;

  // Negative positions clamp to zero, anything above one clamps to one.
  always_comb begin
    if (pos_i[17]) begin
      pos_clamp = '0;
    end else if (pos_i[16:0] > ONE_Q16) begin
      pos_clamp = ONE_Q16;
    end else begin
      pos_clamp = pos_i[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 33'(pos_clamp) * 33'(max_i);
    end
  end

  assign rounded = prod_q + HALF_Q16;
  assign value_o = rounded[31:16];

endmodule
